// ----- sv/dithered_gradient_color_pick_assert.svh -----
// Assertion macros for the dithered gradient color pick block.
// Taken in by the top level; depends on no other file.
`ifndef DITHERED_GRADIENT_COLOR_PICK_ASSERT_SVH
`define DITHERED_GRADIENT_COLOR_PICK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DGCP_ASSERT_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dgcp assertion failed");
// Next-cycle implication, disabled during reset.
`define DGCP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dgcp assertion failed");
`else
`define DGCP_ASSERT_NOW(lbl, clk, rst, pre, post)
`define DGCP_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ----- sv/dgcp_pkg.sv -----
// Shared types and constants for the dithered gradient color pick block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package dgcp_pkg;

  localparam int POS_W    = 16;
  localparam int SPAN_W   = 16;
  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 8;
  localparam int LEN_W    = 9;
  localparam int LENM1_W  = 8;
  localparam int SCALED_W = POS_W + LENM1_W;
  localparam int FRAC_W   = 8;
  localparam int QUO_W    = SCALED_W + FRAC_W;
  localparam int REM_W    = SPAN_W;
  localparam int NUM_CELLS = QUO_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LEN_W;

  // Item opcodes.
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR  = 2'd2;

  // Dither hash weights.
  localparam logic [7:0] HASH_AND_K = 8'd83;
  localparam logic [7:0] HASH_SUM_K = 8'd63;
  localparam logic [7:0] HASH_X_K   = 8'd37;

  // Sideband that travels with an item down the divider chain.
  typedef struct packed {
    logic               op;
    logic [SPAN_W-1:0]  span;
    logic               zero;
    logic [7:0]         hash;
    logic [LENM1_W-1:0] len_m1;
    logic               dither;
    logic [COLOR_W-1:0] start_color;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] entry_color;
  } tag_t;

  // Divider state: partial remainder and the dividend/quotient shift word.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] word;
  } div_t;

endpackage

// ----- sv/dithered_gradient_color_pick.sv -----
// Path of a compute word: front stage, 32 division cells, then the table read register
// that drives out_valid; write words update the table at the end of the chain.
// Throughput: one word per cycle, set by the one-bit cells, unless out_ready stalls it.
// Reset clears every stage valid flag and restores table_length 256, dither off and
// start color 0; the color table keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`include "dithered_gradient_color_pick_assert.svh"
module dithered_gradient_color_pick #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [15:0]                     position,
  input  logic [15:0]                     span,
  input  logic [11:0]                     pixel_x,
  input  logic [11:0]                     pixel_y,
  input  logic [7:0]                      entry_index,
  input  logic [7:0]                      entry_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dgcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dgcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dgcp_pkg::*;

  logic [LEN_W-1:0]   table_length;
  logic               dither_on;
  logic [COLOR_W-1:0] start_color;

  logic               stg_valid [NUM_CELLS+1];
  logic               stg_ready [NUM_CELLS+1];
  tag_t               stg_tag   [NUM_CELLS+1];
  div_t               stg_div   [NUM_CELLS+1];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= LEN_W'(256);
      dither_on    <= 1'b0;
      start_color  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TABLE_LENGTH: table_length <= cfg_data;
        CFG_DITHER_ON:    dither_on    <= cfg_data[0];
        CFG_START_COLOR:  start_color  <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Front stage.
  dgcp_prep #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .span        (span),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .table_length(table_length),
    .dither_on   (dither_on),
    .start_color (start_color),
    .down_valid  (stg_valid[0]),
    .down_ready  (stg_ready[0]),
    .down_tag    (stg_tag[0]),
    .down_div    (stg_div[0])
  );

  // Division chain, one quotient bit per cell.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    dgcp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (stg_valid[i]),
      .up_ready  (stg_ready[i]),
      .up_tag    (stg_tag[i]),
      .up_div    (stg_div[i]),
      .down_valid(stg_valid[i+1]),
      .down_ready(stg_ready[i+1]),
      .down_tag  (stg_tag[i+1]),
      .down_div  (stg_div[i+1])
    );
  end

  // Index selection, table and output register.
  dgcp_pick #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[NUM_CELLS]),
    .up_ready (stg_ready[NUM_CELLS]),
    .up_tag   (stg_tag[NUM_CELLS]),
    .up_div   (stg_div[NUM_CELLS]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .color    (color)
  );

  // An empty front stage always takes a word.
  `DGCP_ASSERT_NOW(a_front_ready, clk, rst, !stg_valid[0], in_ready)
  // A table write at the end of the chain never waits on the output side.
  `DGCP_ASSERT_NOW(a_write_retires, clk, rst,
    stg_valid[NUM_CELLS] && (stg_tag[NUM_CELLS].op == OP_WRITE), stg_ready[NUM_CELLS])
  // A compute word cannot leave the chain while a result is held.
  `DGCP_ASSERT_NOW(a_no_overrun, clk, rst,
    out_valid && !out_ready && (stg_tag[NUM_CELLS].op == OP_COMPUTE), !stg_ready[NUM_CELLS])
  // A compute word taken from the chain shows up as a result next cycle.
  `DGCP_ASSERT_NEXT(a_result_follows, clk, rst,
    stg_valid[NUM_CELLS] && stg_ready[NUM_CELLS] && (stg_tag[NUM_CELLS].op == OP_COMPUTE),
    out_valid)

endmodule

// ----- sv/dgcp_prep.sv -----
// Front stage: takes an input word, scales the position and hashes the pixel.
// Depends on dgcp_pkg.
`timescale 1ns / 1ps
module dgcp_prep #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic                         opcode,
  input  logic [15:0]                  position,
  input  logic [15:0]                  span,
  input  logic [11:0]                  pixel_x,
  input  logic [11:0]                  pixel_y,
  input  logic [7:0]                   entry_index,
  input  logic [7:0]                   entry_color,
  input  logic [dgcp_pkg::LEN_W-1:0]   table_length,
  input  logic                         dither_on,
  input  logic [dgcp_pkg::COLOR_W-1:0] start_color,
  output logic                         down_valid,
  input  logic                         down_ready,
  output dgcp_pkg::tag_t               down_tag,
  output dgcp_pkg::div_t               down_div
);
  import dgcp_pkg::*;

  logic               valid;
  logic [LENM1_W-1:0] len_m1;
  logic [SCALED_W-1:0] scaled;
  logic [7:0]         xy_and;
  logic [7:0]         xy_sum;
  logic [15:0]        prod_and;
  logic [15:0]        prod_sum;
  logic [15:0]        prod_x;
  logic [7:0]         hash;

  // Clamp the table length into one to the table depth, then take one off.
  always_comb begin
    if (table_length == '0) begin
      len_m1 = '0;
    end else if (32'(table_length) > TABLE_DEPTH) begin
      len_m1 = LENM1_W'(TABLE_DEPTH - 1);
    end else begin
      len_m1 = LENM1_W'(table_length - LEN_W'(1));
    end
  end

  assign scaled = SCALED_W'(position) * SCALED_W'(len_m1);

  // The hash is taken modulo 256, so only the low byte of each term matters.
  assign xy_and   = pixel_x[7:0] & pixel_y[7:0];
  assign xy_sum   = pixel_x[7:0] + pixel_y[7:0];
  assign prod_and = {8'd0, xy_and} * {8'd0, HASH_AND_K};
  assign prod_sum = {8'd0, xy_sum} * {8'd0, HASH_SUM_K};
  assign prod_x   = {8'd0, pixel_x[7:0]} * {8'd0, HASH_X_K};
  assign hash     = prod_and[7:0] + prod_sum[7:0] + prod_x[7:0];

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      down_tag.op          <= opcode;
      down_tag.span        <= span;
      down_tag.zero        <= (span == '0);
      down_tag.hash        <= hash;
      down_tag.len_m1      <= len_m1;
      down_tag.dither      <= dither_on;
      down_tag.start_color <= start_color;
      down_tag.entry_index <= entry_index;
      down_tag.entry_color <= entry_color;
      down_div.rem         <= '0;
      down_div.word        <= {scaled, FRAC_W'(0)};
    end
  end

endmodule

// ----- sv/dgcp_cell.sv -----
// One restoring division cell: produces one quotient bit per item per cycle unless the next stage stalls.
// Depends on dgcp_pkg.
`timescale 1ns / 1ps
module dgcp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  dgcp_pkg::tag_t up_tag,
  input  dgcp_pkg::div_t up_div,
  output logic           down_valid,
  input  logic           down_ready,
  output dgcp_pkg::tag_t down_tag,
  output dgcp_pkg::div_t down_div
);
  import dgcp_pkg::*;

  logic             valid;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;
  dgcp_pkg::div_t   div_next;

  // Shift the next dividend bit into the remainder and try the subtraction.
  assign trial = {up_div.rem, up_div.word[QUO_W-1]};
  assign diff  = trial - {1'b0, up_tag.span};
  assign ge    = (trial >= {1'b0, up_tag.span});

  always_comb begin
    div_next.rem  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    div_next.word = {up_div.word[QUO_W-2:0], ge};
  end

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      down_tag <= up_tag;
      down_div <= div_next;
    end
  end

endmodule

// ----- sv/dgcp_pick.sv -----
// Back stage: rounds or dithers the quotient, saturates it and reads the color table.
// Holds the color table memory and the output register; depends on dgcp_pkg.
`timescale 1ns / 1ps
module dgcp_pick #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  dgcp_pkg::tag_t               up_tag,
  input  dgcp_pkg::div_t               up_div,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dgcp_pkg::COLOR_W-1:0] color
);
  import dgcp_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [COLOR_W-1:0]  mem [TABLE_DEPTH];
  logic [SCALED_W-1:0] q_int;
  logic [FRAC_W-1:0]   q_frac;
  logic                inc;
  logic [SCALED_W:0]   idx_sum;
  logic [LENM1_W-1:0]  idx_sat;
  logic [IDX_W-1:0]    rd_addr;
  logic                take;
  logic                load;
  logic                wr_en;
  logic [COLOR_W-1:0]  rd_data;
  logic                zero_q;
  logic [COLOR_W-1:0]  start_q;

  // Dither compares the fraction with the hash; rounding looks at its top bit.
  assign q_int  = up_div.word[QUO_W-1:FRAC_W];
  assign q_frac = up_div.word[FRAC_W-1:0];
  assign inc    = up_tag.dither ? (q_frac > up_tag.hash) : q_frac[FRAC_W-1];

  // Saturate to the last active entry.
  assign idx_sum = {1'b0, q_int} + (SCALED_W + 1)'(inc);
  always_comb begin
    if (idx_sum > (SCALED_W + 1)'(up_tag.len_m1)) begin
      idx_sat = up_tag.len_m1;
    end else begin
      idx_sat = idx_sum[LENM1_W-1:0];
    end
  end
  assign rd_addr = idx_sat[IDX_W-1:0];

  // A write word retires at once; a compute word needs the output register.
  assign up_ready = (up_tag.op == OP_WRITE) || !out_valid || out_ready;
  assign take     = up_valid && up_ready;
  assign load     = take && (up_tag.op == OP_COMPUTE);
  assign wr_en    = take && (up_tag.op == OP_WRITE) &&
                    ({24'd0, up_tag.entry_index} < TABLE_DEPTH);

  // Color table with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[up_tag.entry_index[IDX_W-1:0]] <= up_tag.entry_color;
    end
    if (load) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      zero_q  <= up_tag.zero;
      start_q <= up_tag.start_color;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign color = zero_q ? start_q : rd_data;

endmodule

// ----- bench/dithered_gradient_color_pick_test.sv -----
// Self-checking testbench for the dithered gradient color pick block.
// Depends on dgcp_pkg and dithered_gradient_color_pick; predicts every color word and
// checks it against the block under random valid/ready pressure.
`timescale 1ns / 1ps
module dithered_gradient_color_pick_test;
  import dgcp_pkg::*;

  // Configuration index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned DEPTH = 256;
  localparam int unsigned FRAC_SCALE = 256;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 100;

  typedef struct {
    logic        op;
    logic [15:0] position;
    logic [15:0] span;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  slot;
    logic [7:0]  shade;
  } pick_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_COMPUTE;
  logic [15:0]           position = '0;
  logic [15:0]           span = '0;
  logic [11:0]           pixel_x = '0;
  logic [11:0]           pixel_y = '0;
  logic [7:0]            entry_index = '0;
  logic [7:0]            entry_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            color;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted registers and palette.
  logic [8:0]  cur_len = 9'd256;
  logic        cur_dither = 1'b0;
  logic [7:0]  cur_start = 8'd0;
  logic [7:0]  palette [DEPTH];
  logic        palette_set [DEPTH];

  logic [7:0]  color_due [$];
  int          mismatch_count = 0;

  // Idling controls.
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  int          burst_left = 0;
  logic [15:0] stall_pat = 16'h5A5B;
  logic [5:0]  stall_age = '0;

  dithered_gradient_color_pick u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .position(position),
    .span(span),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .entry_index(entry_index),
    .entry_color(entry_color),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .color(color),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Palette slot that a compute word reads under the current settings.
  function automatic int unsigned grad_index(input logic [15:0] pos, input logic [15:0] sp,
                                             input logic [11:0] px, input logic [11:0] py);
    int unsigned len, scaled, idx, hash, xi, yi, spi;
    len = cur_len;
    xi = px;
    yi = py;
    spi = sp;
    if (len < 1) len = 1;
    if (len > DEPTH) len = DEPTH;
    scaled = pos * (len - 1);
    if (cur_dither) begin
      hash = ((xi & yi) * HASH_AND_K + (xi + yi) * HASH_SUM_K + xi * HASH_X_K) % FRAC_SCALE;
      idx = scaled / spi;
      if (((scaled % spi) * FRAC_SCALE) / spi > hash) idx++;
    end else begin
      idx = (scaled + spi / 2) / spi;
    end
    if (idx > len - 1) idx = len - 1;
    return idx;
  endfunction

  function automatic pick_word_t random_word();
    pick_word_t w;
    w.op = 1'($urandom_range(0, 1));
    w.position = 16'($urandom());
    w.span = 16'($urandom());
    w.x = 12'($urandom());
    w.y = 12'($urandom());
    w.slot = 8'($urandom());
    w.shade = 8'($urandom());
    return w;
  endfunction

  function automatic pick_word_t compute_word(input logic [15:0] pos, input logic [15:0] sp,
                                              input logic [11:0] px, input logic [11:0] py);
    pick_word_t w;
    w = random_word();
    w.op = OP_COMPUTE;
    w.position = pos;
    w.span = sp;
    w.x = px;
    w.y = py;
    return w;
  endfunction

  // Random compute word, weighted toward tiny, huge and zero spans and saturation.
  function automatic pick_word_t random_compute();
    pick_word_t w;
    w = random_word();
    w.op = OP_COMPUTE;
    case ($urandom_range(0, 9))
      0: w.span = 16'd0;
      1, 2, 3: w.span = 16'($urandom_range(1, 16));
      4, 5, 6: w.span = 16'($urandom_range(1, 65535));
      default: w.span = 16'($urandom_range(60000, 65535));
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2: w.position = 16'($urandom_range(w.span, 65535));
      3, 4, 5: w.position = 16'($urandom());
      default: w.position = 16'($urandom_range(0, w.span));
    endcase
    return w;
  endfunction

  task automatic report_miss(input string what, input logic [7:0] want, input logic [7:0] got);
    if (mismatch_count < 10) $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Send one word, with a random gap at the start of each burst, and predict it.
  task automatic send_word(input pick_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap != 0 && !tx_steady) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= w.op;
    position <= w.position;
    span <= w.span;
    pixel_x <= w.x;
    pixel_y <= w.y;
    entry_index <= w.slot;
    entry_color <= w.shade;
    do @(posedge clk); while (!in_ready);
    if (w.op == OP_WRITE) begin
      palette[w.slot] = w.shade;
      palette_set[w.slot] = 1'b1;
    end else if (w.span == 0) begin
      color_due.push_back(cur_start);
    end else begin
      color_due.push_back(palette[grad_index(w.position, w.span, w.x, w.y)]);
    end
  endtask

  // A compute word that would read a never-written slot gets that slot loaded first.
  task automatic issue(input pick_word_t w);
    pick_word_t fill;
    int unsigned slot;
    if (w.op == OP_COMPUTE && w.span != 0) begin
      slot = grad_index(w.position, w.span, w.x, w.y);
      if (!palette_set[slot]) begin
        fill = random_word();
        fill.op = OP_WRITE;
        fill.slot = slot[7:0];
        send_word(fill);
      end
    end
    send_word(w);
  endtask

  // Stop sending, wait for every expected color, then let the pipeline empty.
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && color_due.size() != 0; n++) @(posedge clk);
    while (color_due.size() != 0) report_miss("missing color word", color_due.pop_front(), 8'd0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers plus the spare index; only called while the block is idle.
  task automatic apply_settings(input logic [8:0] len, input logic dith, input logic [7:0] sc);
    logic [CFG_IDX_W-1:0]  idx_list [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    int i;
    idx_list = '{CFG_TABLE_LENGTH, CFG_DITHER_ON, CFG_START_COLOR, CFG_SPARE};
    data_list = '{len, {8'($urandom()), dith}, {1'($urandom()), sc}, 9'($urandom())};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= data_list[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        CFG_TABLE_LENGTH: cur_len = data_list[i];
        CFG_DITHER_ON: cur_dither = data_list[i][0];
        CFG_START_COLOR: cur_start = data_list[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stalls follow a rotating pattern that is reloaded whenever stall_age wraps.
  always @(posedge clk) begin
    if (rx_steady) out_ready <= 1'b1;
    else out_ready <= stall_pat[0];
    if (stall_age == 0) stall_pat <= 16'($urandom()) | 16'h0001;
    else stall_pat <= {stall_pat[0], stall_pat[15:1]};
    stall_age <= stall_age + 1'b1;
  end

  // Compare each accepted color word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (color_due.size() == 0) report_miss("unexpected color word", 8'd0, color);
      else if (color !== color_due[0]) report_miss("color word", color_due.pop_front(), color);
      else void'(color_due.pop_front());
    end
  end

  // Reset settings: zero span, rounding, saturation and the palette extremes.
  task automatic test_reset_defaults();
    pick_word_t w;
    issue(compute_word(16'd0, 16'd0, 12'd0, 12'd0));
    issue(compute_word(16'd0, 16'd1, 12'd0, 12'd0));
    issue(compute_word(16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF));
    issue(compute_word(16'hFFFF, 16'd1, 12'd0, 12'hFFF));
    issue(compute_word(16'd1, 16'd2, 12'hFFF, 12'd0));
    w = random_word();
    w.op = OP_WRITE;
    w.slot = 8'd255;
    w.shade = 8'hFF;
    issue(w);
    w.slot = 8'd0;
    w.shade = 8'h00;
    issue(w);
    issue(compute_word(16'd0, 16'd1, 12'd0, 12'd0));
    w = compute_word(16'hFFFF, 16'd0, 12'hFFF, 12'hFFF);
    w.slot = 8'hFF;
    w.shade = 8'hFF;
    issue(w);
    drain();
  endtask

  // Out-of-range table lengths, both modes, hash extremes and the spare index.
  task automatic test_config_extremes();
    apply_settings(9'd0, 1'b1, 8'hFF);
    issue(compute_word(16'hFFFF, 16'd3, 12'd0, 12'd0));
    issue(compute_word(16'd7, 16'd0, 12'd0, 12'd0));
    issue(compute_word(16'd1, 16'd3, 12'd0, 12'd0));
    drain();
    apply_settings(9'd511, 1'b1, 8'h00);
    issue(compute_word(16'd1, 16'd2, 12'd0, 12'd0));
    issue(compute_word(16'd1, 16'd2, 12'hFFF, 12'hFFF));
    issue(compute_word(16'hFFFF, 16'hFFFE, 12'd1, 12'd2));
    issue(compute_word(16'd0, 16'd0, 12'd5, 12'd9));
    drain();
    apply_settings(9'd257, 1'b0, 8'hA5);
    issue(compute_word(16'd1, 16'd3, 12'd0, 12'd0));
    issue(compute_word(16'hFFFF, 16'd2, 12'd0, 12'd0));
    issue(compute_word(16'd0, 16'd0, 12'd0, 12'd0));
    drain();
  endtask

  // Random phases, each under its own settings and idling style.
  task automatic test_random_traffic();
    pick_word_t w;
    logic [8:0] len;
    logic       dith;
    logic [7:0] sc;
    int phase, n;
    for (phase = 0; phase < PHASES; phase++) begin
      sc = 8'($urandom());
      case (phase)
        0: begin len = 9'd1; dith = 1'b1; sc = 8'hFF; end
        1: begin len = 9'd2; dith = 1'b0; sc = 8'h00; end
        2: begin len = 9'd511; dith = 1'b1; end
        3: begin len = 9'd256; dith = 1'b0; end
        4: begin len = 9'd0; dith = 1'b1; end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(2, 256));
          dith = 1'($urandom_range(0, 1));
        end
      endcase
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 4 == 2);
      apply_settings(len, dith, sc);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          w = random_word();
          w.op = OP_WRITE;
        end else begin
          w = random_compute();
        end
        issue(w);
      end
      drain();
    end
  endtask

  initial begin
    foreach (palette_set[i]) palette_set[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
